FILE: rtl/scli_pkg.sv
// ----------------------------------------------------------------------------
// scli_pkg
// Shared types and constants for the sorted cursor list insert block.
// ----------------------------------------------------------------------------
package scli_pkg;

    localparam int KEY_W     = 64;
    localparam int PAY_W     = 64;
    localparam int PTR_W     = 8;
    localparam int CNT_W     = 8;
    localparam int DEF_NODES = 255;

    localparam logic [PTR_W-1:0] NIL     = 8'hFF;
    localparam logic [CNT_W-1:0] CNT_MAX = 8'hFF;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SPLICE,
        S_LINK,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        OC_INSERTED  = 2'd0,
        OC_DUPLICATE = 2'd1,
        OC_FULL      = 2'd2
    } t_outcome;

    typedef struct packed {
        t_outcome          outcome;
        logic [PTR_W-1:0]  node_used;
        logic [CNT_W-1:0]  inserted_count;
        logic              batch_done;
    } t_result;

endpackage

FILE: rtl/scli_ram.sv
// ----------------------------------------------------------------------------
// scli_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module scli_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

FILE: rtl/scli_walk.sv
// ----------------------------------------------------------------------------
// scli_walk
// Node stores and list sequencer: walks the ordered list one node per cycle,
// then splices a node taken from the free pool when the key is absent.
// ----------------------------------------------------------------------------
module scli_walk
    import scli_pkg::*;
#(
    parameter int NODES = DEF_NODES
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [KEY_W-1:0] i_rec_key,
    input  logic [PAY_W-1:0] i_rec_payload,
    input  logic             i_batch_last,
    output logic             o_res_valid,
    input  logic             i_res_ready,
    output t_result          o_res
);

    localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int SW = $clog2(NODES + 1);
    localparam logic [PTR_W-1:0] L_NODES = PTR_W'(NODES);
    localparam logic [SW-1:0]    L_STEPS = SW'(NODES);

    t_state           r_state, n_state;
    logic [KEY_W-1:0] r_key, n_key;
    logic [PAY_W-1:0] r_payload, n_payload;
    logic             r_last, n_last;
    logic [PTR_W-1:0] r_cur, n_cur;
    logic [PTR_W-1:0] r_prev, n_prev;
    logic [SW-1:0]    r_steps, n_steps;
    logic [PTR_W-1:0] r_list_head, n_list_head;
    logic [PTR_W-1:0] r_free_head, n_free_head;
    logic [CNT_W-1:0] r_count, n_count;
    t_outcome         r_outcome, n_outcome;
    logic [PTR_W-1:0] r_used, n_used;

    logic [PTR_W-1:0] w_raddr;
    logic             w_key_we;
    logic             w_link_we;
    logic [PTR_W-1:0] w_link_waddr;
    logic [PTR_W-1:0] w_link_wdata;
    logic [KEY_W-1:0] w_key_rdata;
    logic [PTR_W-1:0] w_link_rdata;
    logic [PTR_W:0]   w_free_inc;

    scli_ram #(.WIDTH(KEY_W), .DEPTH(NODES)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (w_key_we),
        .i_waddr (r_free_head[AW-1:0]),
        .i_wdata (r_key),
        .i_raddr (w_raddr[AW-1:0]),
        .o_rdata (w_key_rdata)
    );

    scli_ram #(.WIDTH(PAY_W), .DEPTH(NODES)) u_payload_ram (
        .i_clk   (i_clk),
        .i_we    (w_key_we),
        .i_waddr (r_free_head[AW-1:0]),
        .i_wdata (r_payload),
        .i_raddr ({AW{1'b0}}),
        .o_rdata ()
    );

    scli_ram #(.WIDTH(PTR_W), .DEPTH(NODES)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (w_link_we),
        .i_waddr (w_link_waddr[AW-1:0]),
        .i_wdata (w_link_wdata),
        .i_raddr (w_raddr[AW-1:0]),
        .o_rdata (w_link_rdata)
    );

    assign w_free_inc = {1'b0, r_free_head} + (PTR_W+1)'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_list_head <= NIL;
            r_free_head <= '0;
            r_count     <= '0;
        end else begin
            r_state     <= n_state;
            r_list_head <= n_list_head;
            r_free_head <= n_free_head;
            r_count     <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key     <= n_key;
        r_payload <= n_payload;
        r_last    <= n_last;
        r_cur     <= n_cur;
        r_prev    <= n_prev;
        r_steps   <= n_steps;
        r_outcome <= n_outcome;
        r_used    <= n_used;
    end

    always_comb begin
        n_state      = r_state;
        n_key        = r_key;
        n_payload    = r_payload;
        n_last       = r_last;
        n_cur        = r_cur;
        n_prev       = r_prev;
        n_steps      = r_steps;
        n_list_head  = r_list_head;
        n_free_head  = r_free_head;
        n_count      = r_count;
        n_outcome    = r_outcome;
        n_used       = r_used;
        w_raddr      = r_list_head;
        w_key_we     = 1'b0;
        w_link_we    = 1'b0;
        w_link_waddr = r_free_head;
        w_link_wdata = r_cur;
        o_stall      = 1'b1;
        o_res_valid  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    n_key     = i_rec_key;
                    n_payload = i_rec_payload;
                    n_last    = i_batch_last;
                    n_cur     = r_list_head;
                    n_prev    = NIL;
                    n_steps   = '0;
                    if (r_free_head >= L_NODES) begin
                        n_outcome = OC_FULL;
                        n_used    = NIL;
                        n_state   = S_DONE;
                    end else if (r_list_head >= L_NODES) begin
                        n_cur   = NIL;
                        n_state = S_SPLICE;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                w_raddr = w_link_rdata;
                if (r_steps < L_STEPS && w_key_rdata < r_key) begin
                    n_prev  = r_cur;
                    n_steps = r_steps + SW'(1);
                    if (w_link_rdata < L_NODES) begin
                        n_cur = w_link_rdata;
                    end else begin
                        n_cur   = NIL;
                        n_state = S_SPLICE;
                    end
                end else if (w_key_rdata == r_key) begin
                    n_outcome = OC_DUPLICATE;
                    n_used    = NIL;
                    n_state   = S_DONE;
                end else begin
                    n_state = S_SPLICE;
                end
            end
            S_SPLICE: begin
                w_key_we     = 1'b1;
                w_link_we    = 1'b1;
                w_link_waddr = r_free_head;
                w_link_wdata = r_cur;
                n_used       = r_free_head;
                n_outcome    = OC_INSERTED;
                n_free_head  = (w_free_inc < (PTR_W+1)'(NODES)) ? w_free_inc[PTR_W-1:0] : NIL;
                if (r_count != CNT_MAX) begin
                    n_count = r_count + CNT_W'(1);
                end
                if (r_prev < L_NODES) begin
                    n_state = S_LINK;
                end else begin
                    n_list_head = r_free_head;
                    n_state     = S_DONE;
                end
            end
            S_LINK: begin
                w_link_we    = 1'b1;
                w_link_waddr = r_prev;
                w_link_wdata = r_used;
                n_state      = S_DONE;
            end
            S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    if (r_last) begin
                        n_count = '0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_res.outcome        = r_outcome;
    assign o_res.node_used      = r_used;
    assign o_res.inserted_count = r_count;
    assign o_res.batch_done     = r_last;

`ifndef SYNTH
    a_read_on_node: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_READ |-> r_cur < L_NODES)
        else $error("walk reads past the end of the list");

    a_link_write_node: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_link_we |-> w_link_waddr < L_NODES)
        else $error("link write outside the node store");

    a_used_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE |->
            (r_outcome == OC_INSERTED && r_used < L_NODES) ||
            (r_outcome != OC_INSERTED && r_used == NIL))
        else $error("node index disagrees with outcome");

    a_count_after_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SPLICE |=> r_count != '0)
        else $error("insert count not advanced");
`endif

endmodule

FILE: rtl/scli_out.sv
// ----------------------------------------------------------------------------
// scli_out
// Result register: holds one finished result until the consumer takes it.
// ----------------------------------------------------------------------------
module scli_out
    import scli_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_res_valid,
    output logic    o_res_ready,
    input  t_result i_res,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_res
);

    logic    r_valid, n_valid;
    t_result r_res, n_res;

    assign o_res_ready = !r_valid || !i_stall;

    always_comb begin
        n_valid = r_valid;
        n_res   = r_res;
        if (o_res_ready) begin
            n_valid = i_res_valid;
            if (i_res_valid) begin
                n_res = i_res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

FILE: rtl/sorted_cursor_list_insert_top.sv
// ----------------------------------------------------------------------------
// sorted_cursor_list_insert_top
// Sorted record list insert with a free node pool.
// ----------------------------------------------------------------------------
// Each transaction carries a key and payload. The block walks its ordered
// list from the head, reading one node per cycle from the key and link
// memories, and stops at the first key not below the new one. An absent key
// takes the next free node, which is written and spliced in. One result
// follows every transaction: outcome, node index, per-batch insert count.
// An insert passes through the read state once per node read, then the splice
// state, plus a link state when the new node links in after an existing node;
// a duplicate ends in the read state. The walk is bounded by the key/link
// memory read loop, which follows one link per cycle. A full store answers
// without reading the list.
// Nodes are handed out in index order, so no clearing pass follows reset.
// A finished result waits in an output register while the next item starts.
// ----------------------------------------------------------------------------
module sorted_cursor_list_insert_top
    import scli_pkg::*;
#(
    parameter int NODES = DEF_NODES
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [KEY_W-1:0] i_rec_key,
    input  logic [PAY_W-1:0] i_rec_payload,
    input  logic             i_batch_last,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [1:0]       o_outcome,
    output logic [PTR_W-1:0] o_node_used,
    output logic [CNT_W-1:0] o_inserted_count,
    output logic             o_batch_done
);

    logic    w_res_valid;
    logic    w_res_ready;
    t_result w_res;
    t_result w_out;

    scli_walk #(.NODES(NODES)) u_walk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_rec_key     (i_rec_key),
        .i_rec_payload (i_rec_payload),
        .i_batch_last  (i_batch_last),
        .o_res_valid   (w_res_valid),
        .i_res_ready   (w_res_ready),
        .o_res         (w_res)
    );

    scli_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (w_res_valid),
        .o_res_ready (w_res_ready),
        .i_res       (w_res),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_res       (w_out)
    );

    assign o_outcome        = w_out.outcome;
    assign o_node_used      = w_out.node_used;
    assign o_inserted_count = w_out.inserted_count;
    assign o_batch_done     = w_out.batch_done;

endmodule

FILE: tb/sv/sorted_cursor_list_insert_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_cursor_list_insert_top_tb
// Self-checking bench for the sorted record list insert block.
// ----------------------------------------------------------------------------
// A short table of records covers the key extremes, duplicates, batch ends
// and packed-string ordering. Random records follow: new keys, duplicates
// and near neighbors of stored keys, until the node pool runs dry and beyond.
// A local copy of the ordered list and free pool predicts results not fixed in the table.
// Sender gaps and receiver stalls rotate through several patterns, and one
// long receiver hold-off backs the block up into its input.
// ----------------------------------------------------------------------------
module sorted_cursor_list_insert_top_tb;
    import scli_pkg::*;

    localparam int NODES       = DEF_NODES;
    localparam int RAND_ITEMS  = 934;
    localparam int HOLD_CYCLES = 500;
    localparam int QUIET_LIMIT = 5000;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] pay;
        logic             last;
        logic             typed;
        t_outcome         oc;
        logic [PTR_W-1:0] node;
        logic [CNT_W-1:0] cnt;
    } t_row;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_stall;
    logic [KEY_W-1:0] i_rec_key;
    logic [PAY_W-1:0] i_rec_payload;
    logic             i_batch_last;
    logic             o_valid;
    logic             i_stall = 1'b0;
    logic [1:0]       o_outcome;
    logic [PTR_W-1:0] o_node_used;
    logic [CNT_W-1:0] o_inserted_count;
    logic             o_batch_done;

    logic [KEY_W-1:0] node_key [0:NODES-1];
    logic [PTR_W-1:0] node_next [0:NODES-1];
    logic [PTR_W-1:0] order_head;
    logic [PTR_W-1:0] pool_head;
    logic [CNT_W-1:0] batch_inserts;
    logic [KEY_W-1:0] stored_keys [$];

    t_result pending_results [$];
    t_result want;

    int mismatch_count = 0;
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int hold_ask       = 0;
    int hold_seen      = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;

    t_row script [0:15] = '{
        '{64'h0, 64'h0, 1'b0, 1'b1, OC_INSERTED, 8'd0, 8'd1},
        '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1,
          OC_INSERTED, 8'd1, 8'd2},
        '{64'h0, 64'h5555_5555_5555_5555, 1'b0, 1'b1, OC_DUPLICATE, NIL, 8'd2},
        '{64'hFFFF_FFFF_FFFF_FFFF, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 1'b1,
          OC_DUPLICATE, NIL, 8'd2},
        '{64'h4D00_0000_0000_0000, 64'h0123_4567_89AB_CDEF, 1'b0, 1'b0,
          OC_INSERTED, NIL, 8'd0},
        '{64'h4D41_0000_0000_0000, 64'hFEDC_BA98_7654_3210, 1'b0, 1'b0,
          OC_INSERTED, NIL, 8'd0},
        '{64'h4100_0000_0000_0000, 64'h1, 1'b0, 1'b0, OC_INSERTED, NIL, 8'd0},
        '{64'h4142_0000_0000_0000, 64'h2, 1'b1, 1'b0, OC_INSERTED, NIL, 8'd0},
        '{64'h4100_0000_0000_0000, 64'h3, 1'b0, 1'b1, OC_DUPLICATE, NIL, 8'd0},
        '{64'h0000_0000_0000_0001, 64'h4, 1'b0, 1'b0, OC_INSERTED, NIL, 8'd0},
        '{64'hFFFF_FFFF_FFFF_FFFE, 64'h5, 1'b0, 1'b0, OC_INSERTED, NIL, 8'd0},
        '{64'h8000_0000_0000_0000, 64'h6, 1'b0, 1'b0, OC_INSERTED, NIL, 8'd0},
        '{64'h7FFF_FFFF_FFFF_FFFF, 64'h7, 1'b0, 1'b0, OC_INSERTED, NIL, 8'd0},
        '{64'h4142_4344_4546_4748, 64'h8, 1'b0, 1'b0, OC_INSERTED, NIL, 8'd0},
        '{64'h4142_4344_4546_4748, 64'h9, 1'b1, 1'b0, OC_DUPLICATE, NIL, 8'd0},
        '{64'h5A00_0000_0000_0000, 64'hA, 1'b1, 1'b0, OC_INSERTED, NIL, 8'd0}
    };

    sorted_cursor_list_insert_top #(
        .NODES(NODES)
    ) uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_rec_key        (i_rec_key),
        .i_rec_payload    (i_rec_payload),
        .i_batch_last     (i_batch_last),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_outcome        (o_outcome),
        .o_node_used      (o_node_used),
        .o_inserted_count (o_inserted_count),
        .o_batch_done     (o_batch_done)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_result predict_insert(input logic [KEY_W-1:0] k,
                                               input logic l);
        t_result r;
        logic [PTR_W-1:0] prev;
        logic [PTR_W-1:0] cur;
        logic [PTR_W-1:0] n;
        int steps;
        prev  = NIL;
        cur   = order_head;
        steps = 0;
        while (cur < NODES && steps < NODES && node_key[cur] < k) begin
            prev = cur;
            cur  = node_next[cur];
            steps++;
        end
        if (cur >= NODES) cur = NIL;
        r.node_used = NIL;
        if (pool_head >= NODES) begin
            r.outcome = OC_FULL;
        end else if (cur < NODES && node_key[cur] == k) begin
            r.outcome = OC_DUPLICATE;
        end else begin
            n            = pool_head;
            pool_head    = node_next[n];
            node_key[n]  = k;
            node_next[n] = cur;
            if (prev < NODES) node_next[prev] = n;
            else order_head = n;
            r.node_used = n;
            r.outcome   = OC_INSERTED;
            if (batch_inserts != CNT_MAX) batch_inserts++;
            stored_keys.push_back(k);
        end
        r.inserted_count = batch_inserts;
        r.batch_done     = l;
        if (l) batch_inserts = '0;
        return r;
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        logic [KEY_W-1:0] k;
        int n;
        int idx;
        k   = '0;
        n   = $urandom_range(1, 8);
        idx = $urandom_range(stored_keys.size() - 1);
        case ($urandom_range(9))
            0, 1: k = stored_keys[idx];
            2, 3: k = {$urandom, $urandom};
            4, 5, 6: begin
                for (int c = 0; c < n; c++) k[63-8*c -: 8] = 8'(8'h41 + $urandom_range(25));
            end
            7: begin
                if ($urandom_range(1)) k = stored_keys[idx] + 64'd1;
                else k = stored_keys[idx] - 64'd1;
            end
            8: k = 64'($urandom_range(300));
            default: k = ~64'($urandom_range(300));
        endcase
        return k;
    endfunction

    task automatic submit_record(input t_row row);
        t_result predicted;
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_rec_key     <= row.key;
        i_rec_payload <= row.pay;
        i_batch_last  <= row.last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predicted = predict_insert(row.key, row.last);
        if (row.typed) begin
            predicted.outcome        = row.oc;
            predicted.node_used      = row.node;
            predicted.inserted_count = row.cnt;
            predicted.batch_done     = row.last;
        end
        pending_results.push_back(predicted);
    endtask

    always @(posedge i_clk) begin
        if (hold_ask != hold_seen) begin
            hold_seen <= hold_ask;
            hold_left <= HOLD_CYCLES;
            i_stall   <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < sink_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual outcome %0d node %0d",
                         $time, o_outcome, o_node_used);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_outcome != want.outcome) begin
                    $display("%0t: outcome mismatch: expected %0d, actual %0d",
                             $time, want.outcome, o_outcome);
                    mismatch_count++;
                end
                if (o_node_used != want.node_used) begin
                    $display("%0t: node_used mismatch: expected %0d, actual %0d",
                             $time, want.node_used, o_node_used);
                    mismatch_count++;
                end
                if (o_inserted_count != want.inserted_count) begin
                    $display("%0t: inserted_count mismatch: expected %0d, actual %0d",
                             $time, want.inserted_count, o_inserted_count);
                    mismatch_count++;
                end
                if (o_batch_done != want.batch_done) begin
                    $display("%0t: batch_done mismatch: expected %0d, actual %0d",
                             $time, want.batch_done, o_batch_done);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        t_row row;
        int mode;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_rec_key     = '0;
        i_rec_payload = '0;
        i_batch_last  = 1'b0;
        for (int i = 0; i < NODES; i++) begin
            node_key[i]  = '0;
            node_next[i] = (i + 1 < NODES) ? PTR_W'(i + 1) : NIL;
        end
        order_head    = NIL;
        pool_head     = '0;
        batch_inserts = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[r]) submit_record(script[r]);

        for (int i = 0; i < RAND_ITEMS; i++) begin
            mode = (i / 40) % 4;
            case (mode)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 87; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 87; end
                default: begin src_idle_pct = 33; sink_stall_pct = 33; end
            endcase
            if (i == 0) hold_ask++;
            row      = '0;
            row.key  = pick_key();
            row.pay  = {$urandom, $urandom};
            row.last = ($urandom_range(9) == 0);
            submit_record(row);
        end
        i_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (NODES + 8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/scli_pkg.sv
rtl/scli_ram.sv
rtl/scli_walk.sv
rtl/scli_out.sv
rtl/sorted_cursor_list_insert_top.sv
tb/sv/sorted_cursor_list_insert_top_tb.sv
